### rtl/byte_group_number_decoder_top_defines.svh
// assertion macros for the byte group number decoder
// used by the rtl files that carry concurrent assertions
`ifndef BYTE_GROUP_NUMBER_DECODER_TOP_DEFINES_SVH
`define BYTE_GROUP_NUMBER_DECODER_TOP_DEFINES_SVH
// implication property, disabled while reset is asserted
`define BGND_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked during reset too
`define BGND_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/bgnd_pkg.sv
// shared types and constants for the byte group number decoder
// no dependencies
`default_nettype none
package bgnd_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] RegEndian = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKind = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSize = 2'd2;

  typedef enum logic [1:0] {
    KindUnsigned = 2'd0,
    KindSigned   = 2'd1,
    KindFloat    = 2'd2,
    KindSpare    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        partial_group;
    logic        line_last;
  } out_item_t;

  // group record, complete or partial, handed from the gatherer to the converter
  typedef struct packed {
    logic [31:0] num;
    logic [1:0]  nm1;
    kind_e       kind;
    logic        partial;
    logic        eol;
  } grp_t;
endpackage
`default_nettype wire

### rtl/bgnd_stream_if.sv
// valid/ready stream channel carrying a payload of type payload_t
// depends on nothing
`default_nettype none
interface bgnd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/bgnd_gather.sv
// collects bytes into groups, applies byte order and emits group records
// depends on bgnd_pkg
`default_nettype none
module bgnd_gather (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  take_i,
  input  wire  [7:0]           byte_i,
  input  wire                  eol_i,
  input  wire                  endian_i,
  input  wire  [1:0]           kind_i,
  input  wire  [2:0]           size_i,
  output logic                 emit_o,
  output bgnd_pkg::grp_t       grp_o
);
  import bgnd_pkg::*;
  logic [31:0] gath_q, gath_d, full;
  logic [1:0]  cnt_q, cnt_d, nm1;
  logic        done;

  always_comb begin
    priority if (size_i == 3'd0) nm1 = 2'd0;
    else if (size_i > 3'd4) nm1 = 2'd3;
    else nm1 = 2'(size_i - 3'd1);
    full = gath_q;
    unique case (cnt_q)
      2'd0: full[7:0] = byte_i;
      2'd1: full[15:8] = byte_i;
      2'd2: full[23:16] = byte_i;
      default: full[31:24] = byte_i;
    endcase
    done = cnt_q >= nm1;
    emit_o = take_i && (done || eol_i);
    grp_o.nm1 = nm1;
    grp_o.kind = kind_e'(kind_i);
    grp_o.partial = !done;
    grp_o.eol = eol_i;
    grp_o.num = '0;
    if (!endian_i) begin
      unique case (nm1)
        2'd0: grp_o.num = {24'd0, full[7:0]};
        2'd1: grp_o.num = {16'd0, full[15:0]};
        2'd2: grp_o.num = {8'd0, full[23:0]};
        default: grp_o.num = full;
      endcase
    end else begin
      unique case (nm1)
        2'd0: grp_o.num = {24'd0, full[7:0]};
        2'd1: grp_o.num = {16'd0, full[7:0], full[15:8]};
        2'd2: grp_o.num = {8'd0, full[7:0], full[15:8], full[23:16]};
        default: grp_o.num = {full[7:0], full[15:8], full[23:16], full[31:24]};
      endcase
    end
    gath_d = gath_q;
    cnt_d = cnt_q;
    if (take_i) begin
      if (done || eol_i) begin
        gath_d = '0;
        cnt_d = '0;
      end else begin
        gath_d = full;
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gath_q <= '0;
      cnt_q <= '0;
    end else begin
      gath_q <= gath_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

### rtl/bgnd_convert.sv
// converts a group record to 64-bit integer or double bits
// depends on bgnd_pkg
`default_nettype none
module bgnd_convert #(
  parameter int unsigned KeptFractionBits = 13
) (
  input  bgnd_pkg::grp_t       grp_i,
  output logic [63:0]          value_o
);
  import bgnd_pkg::*;
  localparam int unsigned K = KeptFractionBits;

  logic        sign;
  logic [9:0]  ex, emax;
  logic [20:0] m;
  logic [4:0]  f;
  logic [10:0] bias;
  logic [20:0] remv, half, mr;
  logic [4:0]  s;
  logic [4:0]  fr;
  logic        rnd;
  logic [10:0] dexp;
  logic [4:0]  p;
  logic [51:0] frac;
  logic [63:0] fval;
  logic [31:0] num;

  always_comb begin
    num = grp_i.num;
    unique case (grp_i.nm1)
      2'd0: begin sign = num[7];  emax = 10'd15;   f = 5'd3;
        ex = {6'd0, num[6:3]}; m = {18'd0, num[2:0]}; end
      2'd1: begin sign = num[15]; emax = 10'd63;   f = 5'd9;
        ex = {4'd0, num[14:9]}; m = {12'd0, num[8:0]}; end
      2'd2: begin sign = num[23]; emax = 10'd255;  f = 5'd15;
        ex = {2'd0, num[22:15]}; m = {6'd0, num[14:0]}; end
      default: begin sign = num[31]; emax = 10'd1023; f = 5'd21;
        ex = num[30:21]; m = num[20:0]; end
    endcase
    bias = {2'd0, emax[9:1]};
    fr = f;
    mr = m;
    s = '0; remv = '0; half = '0; rnd = 1'b0;
    if (f > 5'(K)) begin
      s = f - 5'(K);
      remv = m & ((21'd1 << s) - 21'd1);
      half = 21'd1 << (s - 5'd1);
      mr = m >> s;
      fr = 5'(K);
      rnd = (remv > half) || (remv == half && mr[0]);
      mr = mr + 21'(rnd);
    end
    p = '0;
    for (int i = 1; i < 21; i++) begin
      if (mr[i]) p = 5'(i);
    end
    dexp = '0;
    frac = '0;
    fval = '0;
    if (ex == emax) begin
      fval = {sign, 11'h7ff, (m != '0), 51'd0};
    end else if (f > 5'(K) && mr == (21'd1 << fr)) begin
      if (ex + 10'd1 == emax) fval = {sign, 11'h7ff, 52'd0};
      else begin
        dexp = 11'(ex) + 11'd1 - bias + 11'd1023;
        fval = {sign, dexp, 52'd0};
      end
    end else if (ex == '0) begin
      if (mr == '0) fval = {sign, 63'd0};
      else begin
        dexp = 11'(p) + 11'd1 - bias - 11'(fr) + 11'd1023;
        frac = (52'(mr) & ((52'd1 << p) - 52'd1)) << (6'd52 - 6'(p));
        fval = {sign, dexp, frac};
      end
    end else begin
      dexp = 11'(ex) - bias + 11'd1023;
      frac = 52'(mr) << (6'd52 - 6'(fr));
      fval = {sign, dexp, frac};
    end
    if (grp_i.partial) value_o = '0;
    else begin
      unique case (grp_i.kind)
        KindFloat: value_o = fval;
        KindSigned: begin
          unique case (grp_i.nm1)
            2'd0: value_o = {{56{num[7]}}, num[7:0]};
            2'd1: value_o = {{48{num[15]}}, num[15:0]};
            2'd2: value_o = {{40{num[23]}}, num[23:0]};
            default: value_o = {{32{num[31]}}, num};
          endcase
        end
        default: value_o = {32'd0, num};
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/byte_group_number_decoder_top.sv
// top level of the byte group number decoder: config, input register, result register
// depends on bgnd_pkg, bgnd_stream_if, bgnd_gather, bgnd_convert
//
// usage:
// - in_s carries one byte and an end-of-line flag per word; out_m carries
//   the 64-bit value, the partial-group flag and the line-last flag
// - bytes are gathered into groups of group_size; a full group, or a line
//   end mid-group, makes one result; other bytes make none
// - a byte is taken into the input register, then gathered and converted
//   combinationally and held in the result register
// - one byte per cycle while out_m does not stall; the converter is combinational
// - when out_m stalls the result holds and the input register fills; in_s
//   ready drops only while both registers are full and out_m stalls
// - reset clears the registers to little-endian, unsigned, group size one
//   and empties the pipeline and the partial group
// - user writes configuration via cfg_we_i/cfg_idx_i/cfg_data_i while idle; unchecked
`default_nettype none
module byte_group_number_decoder_top #(
  parameter int unsigned KEPT_FRACTION_BITS = 13
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [bgnd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [bgnd_pkg::CfgDataW-1:0]    cfg_data_i,
  bgnd_stream_if.sink                      in_s,
  bgnd_stream_if.source                    out_m
);
  import bgnd_pkg::*;
`include "byte_group_number_decoder_top_defines.svh"

  logic       endian_q;
  logic [1:0] kind_q;
  logic [2:0] size_q;
  logic       iv_q;
  in_item_t   ir_q;
  logic       ov_q;
  out_item_t  or_q;
  logic       adv, emit;
  grp_t       grp;
  logic [63:0] val;

  assign adv = iv_q && (!ov_q || out_m.ready);
  assign in_s.ready = !iv_q || adv;

  bgnd_gather u_gather (
    .clk_i, .rst_ni, .take_i(adv), .byte_i(ir_q.data_byte),
    .eol_i(ir_q.end_of_line), .endian_i(endian_q), .kind_i(kind_q),
    .size_i(size_q), .emit_o(emit), .grp_o(grp)
  );
  bgnd_convert #(.KeptFractionBits(KEPT_FRACTION_BITS)) u_convert (
    .grp_i(grp), .value_o(val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      endian_q <= 1'b0; kind_q <= 2'd0; size_q <= 3'd1;
      iv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegEndian: endian_q <= cfg_data_i[0];
          RegKind: kind_q <= cfg_data_i[1:0];
          RegSize: size_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_s.ready) iv_q <= in_s.valid;
      if (adv) ov_q <= emit;
      else if (out_m.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.ready && in_s.valid) ir_q <= in_s.payload;
    if (adv && emit) or_q <= '{value_bits: val, partial_group: grp.partial,
                               line_last: grp.eol};
  end

  assign out_m.valid = ov_q;
  assign out_m.payload = or_q;

  `BGND_ASSERT(a_stall_hold, clk_i, rst_ni,
    ov_q && !out_m.ready |=> ov_q && $stable(or_q), "result lost under stall")
  `BGND_ASSERT(a_partial_zero, clk_i, rst_ni,
    ov_q && or_q.partial_group |-> or_q.value_bits == 64'd0 && or_q.line_last,
    "partial result malformed")
  `BGND_ASSERT(a_ready_full, clk_i, rst_ni,
    !in_s.ready |-> iv_q && ov_q, "input stalled without full pipeline")
endmodule
`default_nettype wire

### verif/byte_group_number_decoder_top_tb.sv
// self-checking testbench for the byte group number decoder top level
// depends on bgnd_pkg, bgnd_stream_if and the decoder rtl
`default_nettype none
module byte_group_number_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgnd_pkg::*;

  localparam int unsigned KeptBits = 13;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 8;

  class decode_scoreboard;
    bit [63:0]   want_value[$];
    bit          want_partial[$];
    bit          want_last[$];
    bit          endian;
    bit [1:0]    kind;
    bit [2:0]    size;
    bit [31:0]   gathered;
    int unsigned count;
    int unsigned errors;
    int unsigned results;
    int unsigned partials;

    function new();
      endian = 1'b0;
      kind = KindUnsigned;
      size = 3'd1;
      gathered = '0;
      count = 0;
      errors = 0;
      results = 0;
      partials = 0;
    endfunction

    function automatic bit [63:0] float_to_double(bit [31:0] num, int unsigned n);
      int unsigned ew;
      int unsigned fw;
      int unsigned fr;
      int unsigned sh;
      int unsigned p;
      bit [63:0] sgn;
      bit [63:0] emax;
      bit [63:0] ex;
      bit [63:0] m;
      bit [63:0] rem;
      bit [63:0] half;
      longint bias;
      longint dexp;
      ew = 2 * n + 2;
      fw = 6 * n - 3;
      sgn = {num[8*n-1], 63'd0};
      emax = (64'd1 << ew) - 1;
      bias = longint'(emax >> 1);
      ex = (64'(num) >> fw) & emax;
      m = 64'(num) & ((64'd1 << fw) - 1);
      fr = fw;
      if (ex == emax) begin
        return (m != 0) ? (sgn | 64'h7FF8000000000000) : (sgn | 64'h7FF0000000000000);
      end
      if (fw > KeptBits) begin
        sh = fw - KeptBits;
        rem = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        m = m >> sh;
        fr = KeptBits;
        if (rem > half || (rem == half && m[0])) m = m + 1;
        if (m == (64'd1 << fr)) begin
          m = 0;
          ex = ex + 1;
          if (ex == emax) return sgn | 64'h7FF0000000000000;
        end
      end
      if (ex == 0) begin
        if (m == 0) return sgn;
        p = 0;
        while ((m >> (p + 1)) != 0) p++;
        dexp = longint'(p) + 1 - bias - longint'(fr) + 1023;
        m = m & ((64'd1 << p) - 1);
        return sgn | (64'(dexp) << 52) | (m << (52 - p));
      end
      dexp = longint'(ex) - bias + 1023;
      return sgn | (64'(dexp) << 52) | (m << (52 - fr));
    endfunction

    function void note_byte(bit [7:0] b, bit eol);
      int unsigned n;
      bit [63:0] num;
      bit [63:0] val;
      n = (size < 1) ? 1 : ((size > 4) ? 4 : size);
      gathered = gathered | (32'(b) << (8 * count));
      count++;
      if (count >= n) begin
        num = 0;
        if (endian) begin
          for (int i = 0; i < n; i++) num = (num << 8) | 64'(gathered[8*i +: 8]);
        end else begin
          num = 64'(gathered) & ((64'd1 << (8 * n)) - 1);
        end
        if (kind == KindFloat) begin
          val = float_to_double(num[31:0], n);
        end else if (kind == KindSigned && num[8*n-1]) begin
          val = num | ~((64'd1 << (8 * n)) - 1);
        end else begin
          val = num;
        end
        want_value.push_back(val);
        want_partial.push_back(1'b0);
        want_last.push_back(eol);
        gathered = 0;
        count = 0;
      end else if (eol) begin
        want_value.push_back(64'd0);
        want_partial.push_back(1'b1);
        want_last.push_back(1'b1);
        gathered = 0;
        count = 0;
      end else begin
        count = count & 3;
      end
    endfunction

    function void check_result(out_item_t got);
      bit [63:0] ev;
      bit ep;
      bit el;
      results++;
      if (got.partial_group) partials++;
      if (want_value.size() == 0) begin
        $error("unexpected result value_bits=%h", got.value_bits);
        errors++;
        return;
      end
      ev = want_value.pop_front();
      ep = want_partial.pop_front();
      el = want_last.pop_front();
      if (got.value_bits !== ev) begin
        $error("value_bits expected %h actual %h", ev, got.value_bits);
        errors++;
      end
      if (got.partial_group !== ep) begin
        $error("partial_group expected %0b actual %0b", ep, got.partial_group);
        errors++;
      end
      if (got.line_last !== el) begin
        $error("line_last expected %0b actual %0b", el, got.line_last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bgnd_stream_if #(.payload_t(in_item_t)) byte_ch ();
  bgnd_stream_if #(.payload_t(out_item_t)) value_ch ();

  byte_group_number_decoder_top #(.KEPT_FRACTION_BITS(KeptBits)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_s(byte_ch.sink), .out_m(value_ch.source)
  );

  decode_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.payload = '0;
    value_ch.ready = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver side: check on accept, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (value_ch.valid && value_ch.ready) sb.check_result(value_ch.payload);
      if ((byte_ch.valid && byte_ch.ready) || (value_ch.valid && value_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      value_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("byte_group_number_decoder_top: mismatch");
      $finish;
    end
  end

  // valid stays high after the accepting edge; the next caller drives it
  task automatic send_byte(bit [7:0] b, bit eol);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.payload <= '{data_byte: b, end_of_line: eol};
    do @(posedge clk_i); while (!byte_ch.ready);
    sb.note_byte(b, eol);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (sb.want_value.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegEndian) sb.endian = val[0];
    else if (idx == RegKind) sb.kind = val[1:0];
    else if (idx == RegSize) sb.size = val;
    @(posedge clk_i);
  endtask

  // set all registers while idle; any partial group is closed first
  task automatic set_mode(bit e, bit [1:0] k, bit [2:0] s);
    if (sb.count != 0) send_byte(8'($urandom), 1'b1);
    wait_drained();
    write_reg(RegEndian, 3'(e));
    write_reg(RegKind, 3'(k));
    write_reg(RegSize, s);
  endtask

  task automatic send_group(int unsigned n, bit [31:0] word);
    for (int i = 0; i < n; i++) send_byte(word[8*i +: 8], (i == n - 1) && $urandom_range(3) == 0);
  endtask

  initial begin
    bit [31:0] w;
    int unsigned n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: integer extremes, float specials, partial groups
    set_mode(1'b0, KindSigned, 3'd4);
    send_group(4, 32'h8000_0000);
    send_group(4, 32'h7FFF_FFFF);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b1);
    set_mode(1'b1, KindUnsigned, 3'd2);
    send_group(2, 32'h0000_FFFF);
    send_group(2, 32'h0000_0000);
    set_mode(1'b1, KindFloat, 3'd4);
    send_group(4, 32'h7FC0_0000);
    send_group(4, 32'h0100_7FFF);
    send_group(4, 32'h0000_0000);
    send_group(4, 32'h0100_0080);
    send_group(4, 32'h0100_00FF);
    send_group(4, 32'hFF3F_FFFF);
    send_group(4, 32'h0000_0001);
    set_mode(1'b0, KindFloat, 3'd1);
    send_byte(8'h78, 1'b0); send_byte(8'h79, 1'b0); send_byte(8'hF8, 1'b0);
    send_byte(8'h01, 1'b1); send_byte(8'h80, 1'b0);
    set_mode(1'b0, KindSpare, 3'd0);
    send_byte(8'hA5, 1'b0);
    set_mode(1'b0, KindUnsigned, 3'd7);
    send_group(4, 32'hDEAD_BEEF);
    // size lowered mid-group
    set_mode(1'b0, KindUnsigned, 3'd4);
    send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b0);
    wait_drained();
    write_reg(RegSize, 3'd2);
    send_byte(8'h33, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 79; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 79; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      set_mode($urandom_range(1), 2'($urandom_range(3)), 3'($urandom_range(7)));
      repeat (58) begin
        if ($urandom_range(9) < 8) begin
          n = (sb.size < 1) ? 1 : ((sb.size > 4) ? 4 : sb.size);
          w = $urandom;
          if ($urandom_range(7) == 0) w = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
          send_group(n, w);
        end else begin
          send_byte(8'($urandom), $urandom_range(1));
        end
      end
      if (ph == 5) wait_drained();
    end
    send_idle_pct = 0;
    wait_drained();
    $display("run covered %0d bytes, %0d results, %0d partial groups", bytes_sent,
             sb.results, sb.partials);
    if (sb.errors == 0 && sb.want_value.size() == 0)
      $display("byte_group_number_decoder_top: match");
    else
      $display("byte_group_number_decoder_top: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
